// ----- hdl/itu2x_pkg.sv -----
// Shared types and constants for the 2x upscaling transpose block.
// No dependencies; imported by the controller, the datapath and the top level.
package itu2x_pkg;

  localparam int PIX_W     = 8;
  localparam int CFG_DW    = 8;
  localparam int CFG_IDX_W = 1;

  // Request codes carried by in_req_type.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_en;
    logic fetch_en;
  } itu2x_cmd_t;

endpackage

// ----- hdl/itu2x_ctrl.sv -----
// Controller for the 2x upscaling transpose block: decodes accepted items
// into datapath commands and tracks the result in flight. Uses itu2x_pkg.
module itu2x_ctrl import itu2x_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       req_type,
  output logic       busy,
  output itu2x_cmd_t cmd,
  output logic       out_strobe
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state_r;
  logic state_nxt;
  logic accept;

  // The frame store takes one access per cycle, so no item is ever held off.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign cmd.load_en  = accept && (req_type == REQ_LOAD);
  assign cmd.fetch_en = accept && (req_type == REQ_FETCH);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: state_nxt = cmd.fetch_en ? ST_EMIT : ST_IDLE;
      ST_EMIT: state_nxt = cmd.fetch_en ? ST_EMIT : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // The registered read data of a fetch is ready in the cycle after acceptance.
  assign out_strobe = (state_r == ST_EMIT);

endmodule

// ----- hdl/itu2x_dp.sv -----
// Datapath for the 2x upscaling transpose block: size registers, load and
// fetch position counters and the frame store. Uses itu2x_pkg.
module itu2x_dp import itu2x_pkg::*; #(
  parameter int MAX_W = 128,
  parameter int MAX_H = 128
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  itu2x_cmd_t           cmd,
  input  logic [PIX_W-1:0]     pixel_in,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_data,
  output logic [PIX_W-1:0]     pixel_out,
  output logic                 row_end,
  output logic                 frame_end
);

  localparam int DEPTH = MAX_W * MAX_H;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LCW   = (MAX_W > 1) ? $clog2(MAX_W) : 1;
  localparam int LRW   = (MAX_H > 1) ? $clog2(MAX_H) : 1;
  localparam int OCW   = $clog2(2 * MAX_H);
  localparam int ORW   = $clog2(2 * MAX_W);
  localparam int SZA   = $clog2(2 * MAX_W + 1);
  localparam int SZB   = $clog2(2 * MAX_H + 1);
  localparam int SZC   = (SZA > SZB) ? SZA : SZB;
  localparam int SZW   = (SZC > CFG_DW + 1) ? SZC : CFG_DW + 1;

  logic [CFG_DW-1:0] width_r;
  logic [CFG_DW-1:0] height_r;
  logic [LRW-1:0]    ld_row_r;
  logic [LCW-1:0]    ld_col_r;
  logic [ORW-1:0]    out_row_r;
  logic [OCW-1:0]    out_col_r;
  logic [PIX_W-1:0]  rd_data_r;
  logic              row_end_r;
  logic              frame_end_r;

  logic [SZW-1:0] w_eff;
  logic [SZW-1:0] h_eff;
  logic [SZW-1:0] ld_col_p1;
  logic [SZW-1:0] ld_row_p1;
  logic [SZW-1:0] out_col_p1;
  logic [SZW-1:0] out_row_p1;
  logic [AW:0]    wr_sum;
  logic [AW:0]    rd_sum;
  logic [AW-1:0]  wr_addr;
  logic [AW-1:0]  rd_addr;
  logic           rend;
  logic           fend;

  logic [PIX_W-1:0] mem [DEPTH];

  // A size of zero acts as one; a size above the maximum saturates.
  always_comb begin
    if (width_r == '0) begin
      w_eff = SZW'(1);
    end else if (SZW'(width_r) > SZW'(MAX_W)) begin
      w_eff = SZW'(MAX_W);
    end else begin
      w_eff = SZW'(width_r);
    end
    if (height_r == '0) begin
      h_eff = SZW'(1);
    end else if (SZW'(height_r) > SZW'(MAX_H)) begin
      h_eff = SZW'(MAX_H);
    end else begin
      h_eff = SZW'(height_r);
    end
  end

  assign ld_col_p1  = SZW'(ld_col_r) + SZW'(1);
  assign ld_row_p1  = SZW'(ld_row_r) + SZW'(1);
  assign out_col_p1 = SZW'(out_col_r) + SZW'(1);
  assign out_row_p1 = SZW'(out_row_r) + SZW'(1);

  assign rend = (out_col_p1 >= (h_eff << 1));
  assign fend = rend && (out_row_p1 >= (w_eff << 1));

  // Counters wrap below their bound, so the positions always lie inside the store.
  assign wr_sum  = (AW+1)'(ld_row_r) * (AW+1)'(MAX_W) + (AW+1)'(ld_col_r);
  assign rd_sum  = (AW+1)'(out_col_r >> 1) * (AW+1)'(MAX_W) + (AW+1)'(out_row_r >> 1);
  assign wr_addr = wr_sum[AW-1:0];
  assign rd_addr = rd_sum[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_en) begin
      mem[wr_addr] <= pixel_in;
    end
    if (cmd.fetch_en) begin
      rd_data_r   <= mem[rd_addr];
      row_end_r   <= rend;
      frame_end_r <= fend;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= CFG_DW'(1);
      height_r  <= CFG_DW'(1);
      ld_row_r  <= '0;
      ld_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WIDTH:  width_r  <= cfg_data;
          REG_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load_en) begin
        if (ld_col_p1 >= w_eff) begin
          ld_col_r <= '0;
          ld_row_r <= (ld_row_p1 >= h_eff) ? '0 : ld_row_p1[LRW-1:0];
        end else begin
          ld_col_r <= ld_col_p1[LCW-1:0];
        end
      end
      if (cmd.fetch_en) begin
        if (rend) begin
          out_col_r <= '0;
          out_row_r <= fend ? '0 : out_row_p1[ORW-1:0];
        end else begin
          out_col_r <= out_col_p1[OCW-1:0];
        end
      end
    end
  end

  assign pixel_out = rd_data_r;
  assign row_end   = row_end_r;
  assign frame_end = frame_end_r;

endmodule

// ----- hdl/image_transpose_upscale_2x.sv -----
// Top level of the 2x upscaling transpose block.
// Depends on itu2x_pkg, itu2x_ctrl and itu2x_dp.
//
//   channel  | ports                                         | flow
//   ---------+-----------------------------------------------+-----------------------
//   input    | start, busy, in_req_type, in_pixel_in         | start && !busy
//   result   | out_strobe, out_pixel_out, out_row_end,       | one-cycle strobe
//            | out_frame_end                                 |
//   config   | cfg_we, cfg_index, cfg_data                   | write when cfg_we
//
// One item is accepted every cycle; busy stays low, since the single-port frame
// store takes one write or one read per cycle. A load gives no result. A fetch
// gives its result in the cycle after acceptance, from the registered store read.
// Reset clears the sizes to one and all positions to zero; the frame store is
// not cleared. The receiver cannot stall, so results never wait.
module image_transpose_upscale_2x import itu2x_pkg::*; #(
  parameter int MAX_W = 128,
  parameter int MAX_H = 128
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_req_type,
  input  logic [PIX_W-1:0]     in_pixel_in,
  output logic                 out_strobe,
  output logic [PIX_W-1:0]     out_pixel_out,
  output logic                 out_row_end,
  output logic                 out_frame_end,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_data
);

  itu2x_cmd_t cmd;

  itu2x_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .req_type   (in_req_type),
    .busy       (busy),
    .cmd        (cmd),
    .out_strobe (out_strobe)
  );

  itu2x_dp #(
    .MAX_W (MAX_W),
    .MAX_H (MAX_H)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .pixel_in  (in_pixel_in),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel_out (out_pixel_out),
    .row_end   (out_row_end),
    .frame_end (out_frame_end)
  );

  // A result only follows an accepted fetch item.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy && (in_req_type == REQ_FETCH)))
    else $error("result strobe without a fetch item one cycle earlier");

  // A load item never produces a result.
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req_type == REQ_LOAD)) |=> !out_strobe)
    else $error("result strobe after a load item");

  // The last pixel of the frame also closes its row.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_frame_end) |-> out_row_end)
    else $error("frame end without row end");

endmodule
